>>> rtl/rpr_pkg.sv
// Shared constants, codes and types for the rational polyphase resampler.
// Self-contained; imported by rtl/rational_polyphase_resampler.sv.
`default_nettype none

package rpr_pkg;

  // default sizing of the stores
  localparam int MAX_PHASES_DEF = 512;
  localparam int MAX_TAPS_DEF   = 1024;
  localparam int HIST_DEPTH_DEF = 1024;
  localparam int COEF_DEPTH_DEF = 65536;

  // results emitted per sample beat, further ones are stepped over
  localparam int MAX_RESULTS = 64;
  localparam int NRES_W      = 7;

  // field widths
  localparam int REQ_W    = 2;
  localparam int SAMPLE_W = 32;
  localparam int CIDX_W   = 16;
  localparam int COEF_W   = 24;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 68;
  localparam int FRAC_W   = 22;

  // configuration register widths and reset values
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int L_W        = 10;
  localparam int M_W        = 12;
  localparam int K_W        = 11;
  localparam int HL_W       = 11;
  localparam logic [L_W-1:0]  PHASE_COUNT_RST = 10'd1;
  localparam logic [M_W-1:0]  STEP_SIZE_RST   = 12'd1;
  localparam logic [K_W-1:0]  TAPS_RST        = 11'd30;
  localparam logic [HL_W-1:0] HIST_LEN_RST    = 11'd33;

  // phase + M stays below 2^13, so the quotient needs 13 bits
  localparam int DIV_W = 13;
  localparam int LAG_W = 16;

  localparam longint SAT_MAX_L = 64'sd2147483647;
  localparam longint SAT_MIN_L = -64'sd2147483648;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_COEF   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_COUNT = 4'd0,
    CFG_STEP_SIZE   = 4'd1,
    CFG_TAPS        = 4'd2,
    CFG_HIST_LEN    = 4'd3
  } cfg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_MAC   = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/rational_polyphase_resampler.sv
// Rational L/M polyphase FIR resampler: history RAM, coefficient RAM, one MAC.
// Depends on rtl/rpr_pkg.sv.
// Flow: after a sample beat is accepted, each output passes through check, K taps
// issued to the MAC, pipe drain, saturate, phase divider and emit (no taps or drain
// when K is 0); skipped outputs pass only through check and the phase divider.
// A new beat is taken only in idle, after all outputs of the last one.
// Reset and clear beats sweep all HIST_DEPTH history RAM entries, input held off.
`default_nettype none

module rational_polyphase_resampler #(
  parameter int MAX_PHASES = rpr_pkg::MAX_PHASES_DEF,
  parameter int MAX_TAPS   = rpr_pkg::MAX_TAPS_DEF,
  parameter int HIST_DEPTH = rpr_pkg::HIST_DEPTH_DEF,
  parameter int COEF_DEPTH = rpr_pkg::COEF_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rpr_pkg::REQ_W-1:0]           req_type,
  input  logic signed [rpr_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [rpr_pkg::CIDX_W-1:0]          coef_index,
  input  logic signed [rpr_pkg::COEF_W-1:0]   coef_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rpr_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                last_of_run,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rpr_pkg::*;

  localparam int PHW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int HAW = $clog2(HIST_DEPTH);
  localparam int HLW = HAW + 1;
  localparam int CAW = $clog2(COEF_DEPTH);
  localparam int PRW = PHW + K_W;

  // configuration
  logic [L_W-1:0]  phase_count;
  logic [M_W-1:0]  step_size;
  logic [K_W-1:0]  taps_per_phase;
  logic [HL_W-1:0] history_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count    <= PHASE_COUNT_RST;
      step_size      <= STEP_SIZE_RST;
      taps_per_phase <= TAPS_RST;
      history_length <= HIST_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PHASE_COUNT: phase_count    <= cfg_data[L_W-1:0];
        CFG_STEP_SIZE:   step_size      <= cfg_data[M_W-1:0];
        CFG_TAPS:        taps_per_phase <= cfg_data[K_W-1:0];
        CFG_HIST_LEN:    history_length <= cfg_data[HL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective (clamped) settings
  logic [L_W-1:0] eff_l;
  logic [M_W-1:0] eff_m;
  logic [K_W-1:0] eff_k;
  logic [HLW-1:0] eff_hl;

  always_comb begin
    if (phase_count == '0)                   eff_l = L_W'(1);
    else if (int'(phase_count) > MAX_PHASES) eff_l = L_W'(MAX_PHASES);
    else                                     eff_l = phase_count;
    eff_m = (step_size == '0) ? M_W'(1) : step_size;
    eff_k = (int'(taps_per_phase) > MAX_TAPS) ? K_W'(MAX_TAPS) : taps_per_phase;
    if (history_length == '0)                   eff_hl = HLW'(1);
    else if (int'(history_length) > HIST_DEPTH) eff_hl = HLW'(HIST_DEPTH);
    else                                        eff_hl = HLW'(history_length);
  end

  // control state
  state_t                 state;
  logic [HAW-1:0]         clr_addr;
  logic [HAW-1:0]         wp;
  logic [PHW-1:0]         phase;
  logic signed [LAG_W-1:0] lag;
  logic [NRES_W-1:0]      nres;
  logic                   emitting;
  logic [K_W-1:0]         tcnt;
  logic [HAW-1:0]         hidx;
  logic [CAW-1:0]         cidx;
  logic                   v1, v2;
  logic [DIV_W-1:0]       dvd;
  logic [DIV_W-1:0]       quo;
  logic [L_W-1:0]         rem;
  logic [3:0]             dcnt;

  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] result;

  // memories
  logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [COEF_W-1:0]   coef_q;
  logic                       hist_we;
  logic [HAW-1:0]             hist_waddr;
  logic signed [SAMPLE_W-1:0] hist_wdata;
  logic                       coef_we;

  logic           in_acc;
  logic [HLW-1:0] wp_inc;
  logic [HAW-1:0] wp_next;
  logic [PRW-1:0] base_prod;
  logic [DIV_W-1:0] raw;
  logic [L_W:0]   rem_sh;
  logic           rem_ge;
  logic [L_W:0]   rem_sub;
  logic signed [ACC_W-1:0] adj, qtr;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign wp_inc  = HLW'(wp) + HLW'(1);
  assign wp_next = (wp_inc >= eff_hl) ? '0 : HAW'(wp_inc);

  assign hist_we    = (state == ST_CLEAR) ||
                      (in_acc && req_type == REQ_SAMPLE);
  assign hist_waddr = (state == ST_CLEAR) ? clr_addr : wp_next;
  assign hist_wdata = (state == ST_CLEAR) ? '0 : sample_in;
  assign coef_we    = in_acc && req_type == REQ_COEF;

  // writes only in idle/clear, read data used only by the MAC: no same-entry overlap
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q <= hist_mem[hidx];
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[CAW'(coef_index)] <= coef_value;
    coef_q <= coef_mem[cidx];
  end

  assign base_prod = PRW'(phase) * PRW'(eff_k);
  assign raw       = DIV_W'(phase) + DIV_W'(eff_m);

  assign rem_sh  = {rem, dvd[DIV_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, eff_l};
  assign rem_sub = rem_sh - {1'b0, eff_l};

  // truncate toward zero, then saturate
  assign adj = acc + (acc[ACC_W-1] ? ACC_W'((64'sd1 <<< FRAC_W) - 64'sd1) : '0);
  assign qtr = adj >>> FRAC_W;

  // MAC pipe: address -> RAM data -> product -> accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_MAC);
      v2 <= v1;
    end
    if (v1) prod <= hist_q * coef_q;
    if (state == ST_CHECK) acc <= '0;
    else if (v2) acc <= acc + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      wp          <= HAW'(HIST_LEN_RST - HL_W'(1));
      phase       <= '0;
      lag         <= -LAG_W'(1);
      nres        <= '0;
      emitting    <= 1'b0;
      tcnt        <= '0;
      dcnt        <= '0;
      out_valid   <= 1'b0;
      last_of_run <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (req_t'(req_type))
              REQ_SAMPLE: begin
                wp    <= wp_next;
                lag   <= lag + LAG_W'(1);
                nres  <= '0;
                state <= ST_CHECK;
              end
              REQ_CLEAR: begin
                wp       <= HAW'(eff_hl - HLW'(1));
                phase    <= '0;
                lag      <= -LAG_W'(1);
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + HAW'(1);
          if (int'(clr_addr) == HIST_DEPTH - 1) state <= ST_IDLE;
        end
        ST_CHECK: begin
          dvd  <= raw;
          rem  <= '0;
          dcnt <= '0;
          if (lag < 0) begin
            state <= ST_IDLE;
          end else if (int'(nres) < MAX_RESULTS) begin
            emitting <= 1'b1;
            hidx     <= wp;
            cidx     <= CAW'(base_prod);
            tcnt     <= '0;
            state    <= (eff_k == '0) ? ST_FIN : ST_MAC;
          end else begin
            emitting <= 1'b0;
            state    <= ST_DIV;
          end
        end
        ST_MAC: begin
          hidx <= (hidx == '0) ? HAW'(eff_hl - HLW'(1)) : hidx - HAW'(1);
          cidx <= cidx + CAW'(1);
          tcnt <= tcnt + K_W'(1);
          if (tcnt == eff_k - K_W'(1)) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!v1 && !v2) state <= ST_FIN;
        end
        ST_FIN: begin
          if (qtr > ACC_W'(SAT_MAX_L))      result <= SAMPLE_W'(SAT_MAX_L);
          else if (qtr < ACC_W'(SAT_MIN_L)) result <= SAMPLE_W'(SAT_MIN_L);
          else                              result <= SAMPLE_W'(qtr);
          state <= ST_DIV;
        end
        ST_DIV: begin
          // restoring divide of (phase + M) by L, one quotient bit a cycle
          dvd  <= dvd << 1;
          rem  <= rem_ge ? L_W'(rem_sub) : L_W'(rem_sh);
          quo  <= {quo[DIV_W-2:0], rem_ge};
          dcnt <= dcnt + 4'd1;
          if (int'(dcnt) == DIV_W - 1) begin
            phase <= PHW'(rem_ge ? L_W'(rem_sub) : L_W'(rem_sh));
            lag   <= lag - $signed(LAG_W'({quo[DIV_W-2:0], rem_ge}));
            state <= emitting ? ST_EMIT : ST_CHECK;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            sample_out  <= result;
            last_of_run <= (lag < 0) || (int'(nres) == MAX_RESULTS - 1);
            nres        <= nres + NRES_W'(1);
            state       <= ST_CHECK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // lag only reaches zero from below, so a filtered output always sees lag zero
  a_lag_zero_in_mac: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> (lag == '0))
    else $error("lag not zero while filtering");

  a_phase_reduced: assert property (@(posedge clk) disable iff (rst)
    ($past(state == ST_DIV) && state != ST_DIV) |-> (L_W'(phase) < eff_l))
    else $error("phase not reduced below L after step");

  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (!v1 && !v2))
    else $error("saturation taken before MAC pipe drained");

  a_no_emit_past_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (int'(nres) < MAX_RESULTS))
    else $error("emit beyond result limit");

endmodule

`default_nettype wire
